[rtl/pgk_pkg.sv]
// Package for the pulse-gated potassium channel: formats, register indexes and exp tables.
package pgk_pkg;

    localparam int EXP_TABLE_BITS = 8;
    localparam int GATE_FRAC_BITS = 16;

    localparam int FRAC_SHIFT = 20 - EXP_TABLE_BITS;
    localparam int TAB_SIZE   = (1 << EXP_TABLE_BITS) + 1;
    localparam int IDX_W      = EXP_TABLE_BITS + 1;
    localparam int Q30_W      = 31;
    localparam int INT_TAB_N  = 32;

    // shared multiplier operand width: conductance times n^4 is the widest operand
    localparam int MUL_W  = (16 + GATE_FRAC_BITS > 32) ? 16 + GATE_FRAC_BITS : 32;
    localparam int PROD_W = 2 * MUL_W;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_MAX_CONDUCTANCE = 3'd0,
        CFG_RISE_RATE       = 3'd1,
        CFG_DECAY_RATE      = 3'd2,
        CFG_THRESHOLD       = 3'd3,
        CFG_TIME_TO_PEAK    = 3'd4,
        CFG_REFRACTORY      = 3'd5,
        CFG_REVERSAL        = 3'd6
    } cfg_idx_t;

    typedef logic [Q30_W-1:0] q30_t;
    typedef logic [TAB_SIZE-1:0][Q30_W-1:0]  frac_tab_t;
    typedef logic [INT_TAB_N-1:0][Q30_W-1:0] int_tab_t;

    // exp(-y), y in Q30 within [0, 1], series truncated after the y^20 term, Q30 result
    function automatic q30_t series_exp(input logic [63:0] y);
        logic [63:0] term;
        longint      sum;
        term = 64'd1 << 30;
        sum  = longint'(1) << 30;
        for (int k = 1; k <= 20; k++) begin
            term = ((term * y) >> 30) / 64'(k);
            if ((k & 1) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > (longint'(1) << 30)) begin
            sum = longint'(1) << 30;
        end
        return q30_t'(sum);
    endfunction

    // e^-k for k = 0..31, repeated product with round-half-up
    function automatic int_tab_t build_int_tab();
        int_tab_t    t;
        q30_t        e1;
        logic [63:0] acc;
        e1   = series_exp(64'd1 << 30);
        t[0] = q30_t'(64'd1 << 30);
        for (int i = 1; i < INT_TAB_N; i++) begin
            acc  = ((64'(t[i-1]) * 64'(e1)) + (64'd1 << 29)) >> 30;
            t[i] = q30_t'(acc);
        end
        return t;
    endfunction

    function automatic frac_tab_t build_frac_tab();
        frac_tab_t t;
        for (int i = 0; i < TAB_SIZE; i++) begin
            t[i] = series_exp((64'(i) << 30) >> EXP_TABLE_BITS);
        end
        return t;
    endfunction

    localparam int_tab_t  INT_TAB  = build_int_tab();
    localparam frac_tab_t FRAC_TAB = build_frac_tab();

endpackage

[rtl/pulse_gated_potassium_channel.sv]
// Top level of the pulse-gated potassium channel: sequencer, state, config and output stage.
// m_tvalid rises once the result state hands the finished word to the output stage.
// The input is closed until then: each word makes eight passes through the one shared
//   multiplier (exponent, interpolation, exp product, gate, two squarings, conductance,
//   current), with a table-read state between the first two and a result state at the
//   end, and a new word is taken only in the idle state.
// A finished result stalls in the result cycle only while the previous word is still unread.
// Reset (aresetn low, synchronous): gate off, no transition recorded, configuration
//   registers zero, output channel empty.
module pulse_gated_potassium_channel
    import pgk_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [47:0]           s_tdata,   // [31:0] sim_time, [47:32] membrane_voltage
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,   // [31:0] channel_current
    output logic [0:0]            m_tuser,   // [0] gate_on
    // configuration writes
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    localparam int G = GATE_FRAC_BITS;

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b00000000001,
        ST_X      = 11'b00000000010,
        ST_LOOK   = 11'b00000000100,
        ST_INTERP = 11'b00000001000,
        ST_EXPM   = 11'b00000010000,
        ST_GATE   = 11'b00000100000,
        ST_SQ1    = 11'b00001000000,
        ST_SQ2    = 11'b00010000000,
        ST_COND   = 11'b00100000000,
        ST_CUR    = 11'b01000000000,
        ST_OUT    = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [15:0] gmax_reg, rise_reg, decay_reg, thr_reg, rev_reg;
    logic [31:0] ttp_reg, refr_reg;

    // channel state
    logic         gate_on_reg;
    logic [31:0]  last_sw_reg;
    logic         has_sw_reg;
    logic [G-1:0] gas_reg;

    // per-word working registers
    logic [31:0]           t_reg;
    logic [15:0]           v_reg;
    logic [31:0]           elapsed_reg;
    logic [16:0]           mag_reg;
    logic                  neg_reg;
    q30_t                  tab_a_reg, tab_diff_reg, int_val_reg;
    logic                  tab_up_reg;
    logic [FRAC_SHIFT-1:0] rem_reg;
    logic                  exp_zero_reg;
    logic [G-1:0]          n_reg;

    // output stage
    logic        m_valid_reg;
    logic [31:0] m_data_reg;
    logic        m_user_reg;

    // shared multiplier
    logic              mul_en;
    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] prod;

    pgk_mul u_mul (
        .aclk   (aclk),
        .mul_en (mul_en),
        .mul_a  (mul_a),
        .mul_b  (mul_b),
        .mul_p  (prod)
    );

    logic in_accept, out_load;
    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign out_load  = (state_reg == ST_OUT) && (!m_valid_reg || m_tready);

    // difference of reversal and membrane voltage, taken as sign and magnitude
    logic [16:0] dv, dv_mag;
    assign dv     = {rev_reg[15], rev_reg} - {s_tdata[47], s_tdata[47:32]};
    assign dv_mag = dv[16] ? (17'd0 - dv) : dv;

    // split of the exponent x = rate * elapsed (units of 2^-20)
    logic [EXP_TABLE_BITS-1:0] tab_idx;
    logic [IDX_W-1:0]          idx_lo, idx_hi;
    q30_t                      ta, tb;
    logic                      k_big;
    assign k_big   = (prod[47:25] != '0);
    assign tab_idx = prod[19:FRAC_SHIFT];
    assign idx_lo  = {1'b0, tab_idx};
    assign idx_hi  = idx_lo + IDX_W'(1);
    assign ta      = FRAC_TAB[idx_lo];
    assign tb      = FRAC_TAB[idx_hi];

    // interpolated fractional exponential
    q30_t delta, fv, e_val;
    assign delta = prod[Q30_W+FRAC_SHIFT-1:FRAC_SHIFT];
    assign fv    = tab_up_reg ? (tab_a_reg + delta) : (tab_a_reg - delta);
    assign e_val = exp_zero_reg ? '0 : prod[30+Q30_W-1:30];

    // gate value from the scaled exponential, saturated just below one
    logic [G:0]   gate_one, gate_op, q_val, n_full;
    logic [G-1:0] n_sat;
    assign gate_one = {1'b1, {G{1'b0}}};
    assign gate_op  = gate_on_reg ? (gate_one - {1'b0, gas_reg}) : {1'b0, gas_reg};
    assign q_val    = prod[30+G:30];
    assign n_full   = gate_on_reg ? (gate_one - q_val) : q_val;
    assign n_sat    = n_full[G] ? {G{1'b1}} : n_full[G-1:0];

    // final current magnitude and saturation
    logic [32:0] cur_mag;
    logic [31:0] cur_val;
    assign cur_mag = prod[G+32:G];
    always_comb begin
        if (neg_reg) begin
            cur_val = (cur_mag > 33'h080000000) ? 32'h80000000 : (32'd0 - cur_mag[31:0]);
        end else begin
            cur_val = (cur_mag > 33'h07FFFFFFF) ? 32'h7FFFFFFF : cur_mag[31:0];
        end
    end

    // gate transition decision, taken once the current is out
    logic passed_on, passed_off, go_off, go_on;
    assign passed_on  = !has_sw_reg || (elapsed_reg > ttp_reg);
    assign passed_off = !has_sw_reg || (elapsed_reg > refr_reg);
    assign go_off     = gate_on_reg && passed_on;
    assign go_on      = !gate_on_reg && passed_off && ($signed(v_reg) > $signed(thr_reg));

    // multiplier operand select: each pass after the first feeds on the previous product
    always_comb begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        unique case (state_reg)
            ST_X: begin
                mul_a = MUL_W'(gate_on_reg ? rise_reg : decay_reg);
                mul_b = MUL_W'(elapsed_reg);
            end
            ST_INTERP: begin
                mul_a = MUL_W'(tab_diff_reg);
                mul_b = MUL_W'(rem_reg);
            end
            ST_EXPM: begin
                mul_a = MUL_W'(int_val_reg);
                mul_b = MUL_W'(fv);
            end
            ST_GATE: begin
                mul_a = MUL_W'(gate_op);
                mul_b = MUL_W'(e_val);
            end
            ST_SQ1: begin
                mul_a = MUL_W'(n_sat);
                mul_b = MUL_W'(n_sat);
            end
            ST_SQ2, ST_COND: begin
                mul_a = MUL_W'(prod[2*G-1:G]);
                mul_b = (state_reg == ST_SQ2) ? MUL_W'(prod[2*G-1:G]) : MUL_W'(gmax_reg);
            end
            ST_CUR: begin
                mul_a = MUL_W'(prod[16+G-1:0]);
                mul_b = MUL_W'(mag_reg);
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_accept) state_next = ST_X;
            ST_X:      state_next = ST_LOOK;
            ST_LOOK:   state_next = ST_INTERP;
            ST_INTERP: state_next = ST_EXPM;
            ST_EXPM:   state_next = ST_GATE;
            ST_GATE:   state_next = ST_SQ1;
            ST_SQ1:    state_next = ST_SQ2;
            ST_SQ2:    state_next = ST_COND;
            ST_COND:   state_next = ST_CUR;
            ST_CUR:    state_next = ST_OUT;
            ST_OUT:    if (out_load) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // configuration writes; an index past the list is dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gmax_reg  <= '0;
            rise_reg  <= '0;
            decay_reg <= '0;
            thr_reg   <= '0;
            ttp_reg   <= '0;
            refr_reg  <= '0;
            rev_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_MAX_CONDUCTANCE: gmax_reg  <= cfg_wr_data[15:0];
                CFG_RISE_RATE:       rise_reg  <= cfg_wr_data[15:0];
                CFG_DECAY_RATE:      decay_reg <= cfg_wr_data[15:0];
                CFG_THRESHOLD:       thr_reg   <= cfg_wr_data[15:0];
                CFG_TIME_TO_PEAK:    ttp_reg   <= cfg_wr_data;
                CFG_REFRACTORY:      refr_reg  <= cfg_wr_data;
                CFG_REVERSAL:        rev_reg   <= cfg_wr_data[15:0];
                default: ;
            endcase
        end
    end

    // working registers: latch the word, then the table reads, then n
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            t_reg       <= s_tdata[31:0];
            v_reg       <= s_tdata[47:32];
            elapsed_reg <= s_tdata[31:0] - last_sw_reg;
            mag_reg     <= dv_mag;
            neg_reg     <= dv[16];
        end
        if (state_reg == ST_LOOK) begin
            tab_a_reg    <= ta;
            tab_up_reg   <= (ta < tb);
            tab_diff_reg <= (ta < tb) ? (tb - ta) : (ta - tb);
            rem_reg      <= prod[FRAC_SHIFT-1:0];
            int_val_reg  <= INT_TAB[prod[24:20]];
            // no transition yet, or integer part beyond the table: exponential is zero
            exp_zero_reg <= !has_sw_reg || k_big;
        end
        if (state_reg == ST_SQ1) begin
            n_reg <= n_sat;
        end
    end

    // channel state: advance only when the result goes to the output stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gate_on_reg <= 1'b0;
            last_sw_reg <= '0;
            has_sw_reg  <= 1'b0;
            gas_reg     <= '0;
        end else if (out_load && (go_on || go_off)) begin
            gate_on_reg <= go_on;
            last_sw_reg <= t_reg;
            has_sw_reg  <= 1'b1;
            gas_reg     <= n_reg;
        end
    end

    // output stage: hold the word until the sink takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= cur_val;
            m_user_reg <= go_on || (gate_on_reg && !go_off);
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_user_reg;

    // once a transition is recorded it stays recorded
    a_has_sw_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !$fell(has_sw_reg))
        else $error("transition flag cleared outside reset");

    // the gate flag on the output always matches the stored gate state
    a_user_tracks_gate: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[0] == gate_on_reg))
        else $error("output gate flag differs from gate state");

    // an accepted word keeps the input closed while it is worked on
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> !s_tready)
        else $error("input ready right after acceptance");

    // a result handed to the output stage shows up as valid
    a_load_gives_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_tvalid)
        else $error("loaded result not presented");

endmodule

[rtl/pgk_mul.sv]
// Shared unsigned multiplier with registered product, loaded on enable.
module pgk_mul
    import pgk_pkg::*;
(
    input  logic              aclk,
    input  logic              mul_en,
    input  logic [MUL_W-1:0]  mul_a,
    input  logic [MUL_W-1:0]  mul_b,
    output logic [PROD_W-1:0] mul_p
);

    logic [PROD_W-1:0] prod_reg;

    // hold the product while idle so the sequencer can read it later
    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
    end

    assign mul_p = prod_reg;

endmodule
